@@ rtl/rlcfd_pkg.sv @@
// shared types and constants for the rgb led chain frame driver
`default_nettype none

package rlcfd_pkg;

	localparam int LED_COUNT = 16;
	localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int WORD_CNT  = LED_COUNT + 2;
	localparam int WCNT_W    = $clog2(WORD_CNT);
	localparam int WORD_W    = 32;
	localparam int BIT_CNT_W = $clog2(WORD_W);
	localparam int COLOR_W   = 24;

	localparam logic [7:0] HEADER_BYTE = 8'hFF;

	typedef enum logic [1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_CLEAR   = 2'd2,
		FUNC_REFRESH = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic [7:0]  led_index;
		logic [7:0]  red_level;
		logic [7:0]  green_level;
		logic [7:0]  blue_level;
	} cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] frame_word;
		logic              is_frame;
		logic              last;
		logic [7:0]        read_red;
		logic [7:0]        read_green;
		logic [7:0]        read_blue;
		logic              index_bad;
	} rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} shift_stat_t;

endpackage

`default_nettype wire

@@ rtl/rgb_led_chain_frame_driver_unit.sv @@
// top level: colour store, command sequencer and frame output for an rgb led chain
// write goes through a write state before its response state; read, clear and bad index go straight to it
// refresh when dirty gives LED_COUNT + 2 words, each sent through the 32-bit serial shifter
// refresh when clean gives no word and the next command is taken in the following cycle
// one command at a time; the next is taken while a finished word waits on rsp
// reset clears per-led nonzero flags and dirty, so every led reads as zero until written
`default_nettype none

module rgb_led_chain_frame_driver_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  rlcfd_pkg::cmd_t     cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output rlcfd_pkg::rsp_t     rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_RESP,
		ST_READ,
		ST_LOAD,
		ST_SHIFT,
		ST_PUSH
	} state_t;

	localparam logic [rlcfd_pkg::WCNT_W-1:0] END_IDX =
		rlcfd_pkg::WCNT_W'(rlcfd_pkg::LED_COUNT + 1);
	localparam logic [rlcfd_pkg::WCNT_W-1:0] LED_END =
		rlcfd_pkg::WCNT_W'(rlcfd_pkg::LED_COUNT);
	localparam logic [7:0] LED_LIMIT = 8'(rlcfd_pkg::LED_COUNT);

	state_t                            state_q;
	rlcfd_pkg::cmd_t                   cmd_q;
	logic [rlcfd_pkg::LED_COUNT-1:0]   nz_q;
	logic                              dirty_q;
	logic [rlcfd_pkg::WCNT_W-1:0]      wcnt_q;
	rlcfd_pkg::rsp_t                   rsp_q;
	logic                              rsp_valid_q;

	logic [rlcfd_pkg::COLOR_W-1:0]     mem_q [rlcfd_pkg::LED_COUNT];
	logic [rlcfd_pkg::COLOR_W-1:0]     mem_rd_q;

	logic                              accept;
	logic                              out_free;
	logic                              rsp_load;
	logic                              in_good;
	logic                              cmd_good;
	logic [rlcfd_pkg::IDX_W-1:0]       in_idx;
	logic [rlcfd_pkg::IDX_W-1:0]       cmd_idx;
	logic [rlcfd_pkg::WCNT_W-1:0]      led_sel;
	logic [rlcfd_pkg::IDX_W-1:0]       led_idx;
	logic                              led_word;
	logic [rlcfd_pkg::COLOR_W-1:0]     new_color;
	logic [rlcfd_pkg::COLOR_W-1:0]     cmd_stored;
	logic [rlcfd_pkg::COLOR_W-1:0]     led_stored;
	logic                              changed;
	logic                              mem_we;
	logic                              mem_re;
	logic [rlcfd_pkg::IDX_W-1:0]       mem_ra;
	logic                              sh_load;
	logic [rlcfd_pkg::WORD_W-1:0]      sh_word;
	logic [rlcfd_pkg::WORD_W-1:0]      sh_rx;
	rlcfd_pkg::shift_stat_t            sh_stat;
	rlcfd_pkg::rsp_t                   single_rsp;
	rlcfd_pkg::rsp_t                   frame_rsp;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = ((state_q == ST_RESP) || (state_q == ST_PUSH)) && out_free;

	assign in_good  = cmd.led_index < LED_LIMIT;
	assign cmd_good = cmd_q.led_index < LED_LIMIT;
	assign in_idx   = cmd.led_index[rlcfd_pkg::IDX_W-1:0];
	assign cmd_idx  = cmd_q.led_index[rlcfd_pkg::IDX_W-1:0];
	assign led_sel  = wcnt_q - 1'b1;
	assign led_idx  = led_sel[rlcfd_pkg::IDX_W-1:0];
	assign led_word = (wcnt_q != '0) && (wcnt_q <= LED_END);

	// colour layout matches the frame word: blue, green, red
	assign new_color  = {cmd_q.blue_level, cmd_q.green_level, cmd_q.red_level};
	assign cmd_stored = nz_q[cmd_idx] ? mem_rd_q : '0;
	assign led_stored = nz_q[led_idx] ? mem_rd_q : '0;
	assign changed    = (cmd_stored != new_color);

	assign mem_we = (state_q == ST_WRITE) && changed;
	assign mem_re = (accept && in_good) || ((state_q == ST_READ) && led_word);
	assign mem_ra = (state_q == ST_READ) ? led_idx : in_idx;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[cmd_idx] <= new_color;
		end
		if (mem_re) begin
			mem_rd_q <= mem_q[mem_ra];
		end
	end

	assign sh_load = (state_q == ST_LOAD);

	always_comb begin
		if (wcnt_q == '0) begin
			sh_word = '0;
		end else if (wcnt_q == END_IDX) begin
			sh_word = '1;
		end else begin
			sh_word = {rlcfd_pkg::HEADER_BYTE, led_stored};
		end
	end

	rlcfd_shift u_shift (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (sh_load),
		.word    (sh_word),
		.stat    (sh_stat),
		.rx_word (sh_rx)
	);

	always_comb begin
		single_rsp      = '0;
		single_rsp.last = 1'b1;
		if (cmd_q.func == rlcfd_pkg::FUNC_WRITE || cmd_q.func == rlcfd_pkg::FUNC_READ) begin
			single_rsp.index_bad = !cmd_good;
		end
		if (cmd_q.func == rlcfd_pkg::FUNC_READ && cmd_good) begin
			single_rsp.read_blue  = cmd_stored[23:16];
			single_rsp.read_green = cmd_stored[15:8];
			single_rsp.read_red   = cmd_stored[7:0];
		end
	end

	always_comb begin
		frame_rsp            = '0;
		frame_rsp.frame_word = sh_rx;
		frame_rsp.is_frame   = 1'b1;
		frame_rsp.last       = (wcnt_q == END_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			nz_q        <= '0;
			dirty_q     <= 1'b0;
			wcnt_q      <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						unique case (cmd.func)
							rlcfd_pkg::FUNC_WRITE: begin
								state_q <= in_good ? ST_WRITE : ST_RESP;
							end
							rlcfd_pkg::FUNC_READ: begin
								state_q <= ST_RESP;
							end
							rlcfd_pkg::FUNC_CLEAR: begin
								dirty_q <= dirty_q | (|nz_q);
								nz_q    <= '0;
								state_q <= ST_RESP;
							end
							rlcfd_pkg::FUNC_REFRESH: begin
								if (dirty_q) begin
									wcnt_q  <= '0;
									state_q <= ST_READ;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WRITE: begin
					if (changed) begin
						nz_q[cmd_idx] <= |new_color;
						dirty_q       <= 1'b1;
					end
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						rsp_q   <= single_rsp;
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (sh_stat.done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						rsp_q <= frame_rsp;
						if (wcnt_q == END_IDX) begin
							dirty_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							wcnt_q  <= wcnt_q + 1'b1;
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_done_in_shift: assert property (@(posedge clk) disable iff (!arst_n)
		sh_stat.done |-> (state_q == ST_SHIFT))
		else $error("shifter finished outside shift phase");

	a_wcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH) |-> (wcnt_q <= END_IDX))
		else $error("frame word count out of range");

	a_end_clears_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH && out_free && wcnt_q == END_IDX) |=> !dirty_q)
		else $error("dirty still set after end word");

	a_same_color_keeps_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE && !changed) |=> (dirty_q == $past(dirty_q)))
		else $error("unchanged colour altered dirty");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sh_stat.busy |-> cmd_stall)
		else $error("command taken while shifting");

endmodule

`default_nettype wire

@@ rtl/rlcfd_shift.sv @@
// bit-serial frame shifter: sends a word msb first and collects it back one bit per clock
`default_nettype none

module rlcfd_shift (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load,
	input  logic [rlcfd_pkg::WORD_W-1:0]    word,
	output rlcfd_pkg::shift_stat_t          stat,
	output logic [rlcfd_pkg::WORD_W-1:0]    rx_word
);

	localparam logic [rlcfd_pkg::BIT_CNT_W-1:0] LAST_BIT =
		rlcfd_pkg::BIT_CNT_W'(rlcfd_pkg::WORD_W - 1);

	logic [rlcfd_pkg::WORD_W-1:0]    tx_q;
	logic [rlcfd_pkg::WORD_W-1:0]    rx_q;
	logic [rlcfd_pkg::BIT_CNT_W-1:0] cnt_q;
	logic                            busy_q;
	logic                            done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_BIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// serial data line: msb of tx feeds the collector
	always_ff @(posedge clk) begin
		if (load) begin
			tx_q <= word;
		end else if (busy_q) begin
			tx_q <= {tx_q[rlcfd_pkg::WORD_W-2:0], 1'b0};
			rx_q <= {rx_q[rlcfd_pkg::WORD_W-2:0], tx_q[rlcfd_pkg::WORD_W-1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rx_word   = rx_q;

endmodule

`default_nettype wire
